// ----- rtl/cbc_pkg.sv -----
// cbc_pkg: shared types, seed constants and variant codes for the boot checksum core
// no dependencies; imported by the front, back and top modules of the block

package cbc_pkg;

    localparam int WORD_W = 32;
    localparam int VAR_W  = 2;
    localparam int ROT_W  = 5;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [VAR_W-1:0]  t_variant;

    // variant codes
    localparam t_variant VAR_6102 = 2'd0;
    localparam t_variant VAR_6103 = 2'd1;
    localparam t_variant VAR_6105 = 2'd2;
    localparam t_variant VAR_6106 = 2'd3;

    // accumulator seeds
    localparam t_word SEED_6102 = 32'hF8CA_4DDC;
    localparam t_word SEED_6103 = 32'hA388_6759;
    localparam t_word SEED_6105 = 32'hDF26_F436;
    localparam t_word SEED_6106 = 32'h1FEA_617A;

    typedef struct packed {
        t_word image_word;
        t_word boot_word;
        logic  last;
    } t_in_item;

    typedef struct packed {
        t_word checksum_first;
        t_word checksum_second;
    } t_out_item;

    // accumulator snapshot taken on the last word of a region
    typedef struct packed {
        t_variant variant;
        t_word    plain_sum;
        t_word    carry_count;
        t_word    xor_sum;
        t_word    rotate_sum;
        t_word    compare_mix;
        t_word    mix_acc;
    } t_snap;

    function automatic t_word seed_of(input t_variant v);
        t_word s;
        unique case (v)
            VAR_6102: s = SEED_6102;
            VAR_6103: s = SEED_6103;
            VAR_6105: s = SEED_6105;
            VAR_6106: s = SEED_6106;
            default:  s = SEED_6102;
        endcase
        return s;
    endfunction

endpackage

// ----- rtl/cbc_fifo.sv -----
// cbc_fifo: small register queue with full/empty flags
// no package dependency; used between front and back and at the result side

module cbc_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               wr_en, rd_en;

    assign o_full  = (r_count == COUNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/cbc_front.sv -----
// cbc_front: variant register and the six running accumulators, one word per cycle while the snapshot queue is not full
// depends on cbc_pkg; hands a snapshot to the snapshot queue on the last word

module cbc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  cbc_pkg::t_variant i_cfg_wdata,
    input  logic              i_push,
    input  cbc_pkg::t_in_item i_item,
    input  logic              i_snap_full,
    output logic              o_full,
    output logic              o_snap_push,
    output cbc_pkg::t_snap    o_snap
);
    import cbc_pkg::*;

    t_variant r_variant;
    t_word    r_plain, r_carry, r_xor, r_rot, r_cmp, r_mix;
    t_word    n_plain, n_carry, n_xor, n_rot, n_cmp, n_mix;

    logic             accept;
    t_word            d;
    logic [WORD_W:0]  sum_ext;
    logic [ROT_W-1:0] rot_amt;
    logic [2*WORD_W-1:0] rot_wide;
    t_word            rot_word;
    t_word            seed_cfg, seed_cur;

    assign o_full  = i_snap_full;
    assign accept  = i_push && !i_snap_full;
    assign d       = i_item.image_word;

    always_comb begin
        sum_ext  = {1'b0, r_plain} + {1'b0, d};
        rot_amt  = d[ROT_W-1:0];
        rot_wide = {d, d} << rot_amt;
        rot_word = rot_wide[2*WORD_W-1:WORD_W];

        n_plain = sum_ext[WORD_W-1:0];
        n_carry = r_carry + {{(WORD_W-1){1'b0}}, sum_ext[WORD_W]};
        n_xor   = r_xor ^ d;
        n_rot   = r_rot + rot_word;
        if (r_cmp > d) begin
            n_cmp = r_cmp ^ rot_word;
        end else begin
            n_cmp = r_cmp ^ n_plain ^ d;
        end
        if (r_variant == VAR_6105) begin
            n_mix = r_mix + (i_item.boot_word ^ d);
        end else begin
            n_mix = r_mix + (n_rot ^ d);
        end
    end

    assign o_snap_push = accept && i_item.last;
    assign o_snap      = '{variant:     r_variant,
                           plain_sum:   n_plain,
                           carry_count: n_carry,
                           xor_sum:     n_xor,
                           rotate_sum:  n_rot,
                           compare_mix: n_cmp,
                           mix_acc:     n_mix};

    assign seed_cfg = seed_of(i_cfg_wdata);
    assign seed_cur = seed_of(r_variant);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant <= VAR_6102;
            r_plain   <= SEED_6102;
            r_carry   <= SEED_6102;
            r_xor     <= SEED_6102;
            r_rot     <= SEED_6102;
            r_cmp     <= SEED_6102;
            r_mix     <= SEED_6102;
        end else if (i_cfg_we) begin
            r_variant <= i_cfg_wdata;
            r_plain   <= seed_cfg;
            r_carry   <= seed_cfg;
            r_xor     <= seed_cfg;
            r_rot     <= seed_cfg;
            r_cmp     <= seed_cfg;
            r_mix     <= seed_cfg;
        end else if (accept) begin
            if (i_item.last) begin
                r_plain <= seed_cur;
                r_carry <= seed_cur;
                r_xor   <= seed_cur;
                r_rot   <= seed_cur;
                r_cmp   <= seed_cur;
                r_mix   <= seed_cur;
            end else begin
                r_plain <= n_plain;
                r_carry <= n_carry;
                r_xor   <= n_xor;
                r_rot   <= n_rot;
                r_cmp   <= n_cmp;
                r_mix   <= n_mix;
            end
        end
    end

endmodule

// ----- rtl/cbc_back.sv -----
// cbc_back: finalization of a snapshot, multiply or xor stage then add/xor
// depends on cbc_pkg; reads the snapshot queue and writes the result queue

module cbc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_snap_empty,
    input  cbc_pkg::t_snap     i_snap,
    input  logic               i_res_full,
    output logic               o_snap_pop,
    output logic               o_res_push,
    output cbc_pkg::t_out_item o_res
);
    import cbc_pkg::*;

    logic     r_valid;
    t_variant r_variant;
    t_word    r_first_a, r_first_b, r_second_a, r_second_b;
    t_word    n_first_a, n_second_a;
    logic [2*WORD_W-1:0] prod_first, prod_second;
    logic     advance, load;
    t_word    res_first, res_second;

    assign advance    = r_valid && !i_res_full;
    assign load       = !i_snap_empty && (!r_valid || advance);
    assign o_snap_pop = load;
    assign o_res_push = advance;

    // first operands: low products for 6106, plain ^ carry and rotate ^ compare otherwise
    always_comb begin
        prod_first  = i_snap.plain_sum * i_snap.carry_count;
        prod_second = i_snap.rotate_sum * i_snap.compare_mix;
        if (i_snap.variant == VAR_6106) begin
            n_first_a  = prod_first[WORD_W-1:0];
            n_second_a = prod_second[WORD_W-1:0];
        end else begin
            n_first_a  = i_snap.plain_sum ^ i_snap.carry_count;
            n_second_a = i_snap.rotate_sum ^ i_snap.compare_mix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_variant  <= i_snap.variant;
            r_first_a  <= n_first_a;
            r_first_b  <= i_snap.xor_sum;
            r_second_a <= n_second_a;
            r_second_b <= i_snap.mix_acc;
        end
    end

    always_comb begin
        unique case (r_variant) inside
            VAR_6103, VAR_6106: begin
                res_first  = r_first_a + r_first_b;
                res_second = r_second_a + r_second_b;
            end
            default: begin
                res_first  = r_first_a ^ r_first_b;
                res_second = r_second_a ^ r_second_b;
            end
        endcase
    end

    assign o_res = '{checksum_first: res_first, checksum_second: res_second};

endmodule

// ----- rtl/cartridge_boot_checksum_core.sv -----
// cartridge_boot_checksum_core: top level of the cartridge boot checksum block
// depends on cbc_pkg, cbc_fifo, cbc_front and cbc_back

// Boot checksum engine for a cartridge image region. Image words stream in
// through a queue-style port (push/full); each transfer updates six 32-bit
// accumulators, so a word can be pushed every clock while full is low. The
// word flagged last closes the region: the front end copies the updated
// accumulators into a snapshot queue and reseeds for the next region at once.
// The back end pulls snapshots, forms the two checksum words (xor, add, or a
// registered 32x32 multiply then add, per variant) and places them in a result
// queue read through empty/pop. A result passes through the snapshot queue,
// the back end register and the result queue before it can be popped;
// throughput is one word per cycle while full is low, limited only by the
// accumulator feedback loop (add, rotate, compare, xor, add).
// full is raised while the snapshot queue is full, i.e. when results are not
// being popped.
// The variant register (i_cfg_we/i_cfg_wdata) selects seed and finalization;
// writing it reseeds all accumulators and must be done with the block idle.
// The boot word is used only by the 6105 variant.

module cartridge_boot_checksum_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  cbc_pkg::t_variant  i_cfg_wdata,
    // image word side
    input  logic               push,
    output logic               full,
    input  cbc_pkg::t_in_item  i_item,
    // result side
    output logic               empty,
    input  logic               pop,
    output cbc_pkg::t_out_item o_result
);
    import cbc_pkg::*;

    localparam int SNAP_W = $bits(t_snap);
    localparam int RES_W  = $bits(t_out_item);

    // front to snapshot queue
    logic        snap_push, snap_full;
    t_snap       snap_in;
    // snapshot queue to back end
    logic        snap_pop, snap_empty;
    logic [SNAP_W-1:0] snap_q_data;
    // back end to result queue
    logic        res_push, res_full;
    t_out_item   res_in;
    logic [RES_W-1:0]  res_q_data;

    // accumulators, one transfer per cycle while the snapshot queue is not full
    cbc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_item      (i_item),
        .i_snap_full (snap_full),
        .o_full      (full),
        .o_snap_push (snap_push),
        .o_snap      (snap_in)
    );

    // decouples accumulation from finalization
    cbc_fifo #(
        .WIDTH (SNAP_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_snap_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (snap_push),
        .i_data  (snap_in),
        .i_pop   (snap_pop),
        .o_full  (snap_full),
        .o_empty (snap_empty),
        .o_data  (snap_q_data)
    );

    // finalization
    cbc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_empty (snap_empty),
        .i_snap       (t_snap'(snap_q_data)),
        .i_res_full   (res_full),
        .o_snap_pop   (snap_pop),
        .o_res_push   (res_push),
        .o_res        (res_in)
    );

    // result queue, isolates the consumer's pop from the pipeline
    cbc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .i_pop   (pop),
        .o_full  (res_full),
        .o_empty (empty),
        .o_data  (res_q_data)
    );

    assign o_result = t_out_item'(res_q_data);

endmodule

// ----- sim/cbc_checker.sv -----
// cbc_checker: watches both queue ports of the boot checksum core, predicts checksums
// depends on cbc_pkg for the item, result and variant types and the seed constants
`timescale 1ns / 1ps

module cbc_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  cbc_pkg::t_variant  i_cfg_wdata,
    input  logic               i_push,
    input  logic               i_full,
    input  cbc_pkg::t_in_item  i_item,
    input  logic               i_empty,
    input  logic               i_pop,
    input  cbc_pkg::t_out_item i_result,
    output int                 o_fail_count,
    output int                 o_pending
);
    import cbc_pkg::*;

    localparam int PRINT_CAP = 40;

    t_variant  cur_variant;
    t_word     plain_sum, carry_count, xor_sum, rotate_sum, compare_mix, mix_acc;
    t_out_item checksum_q[$];
    int        n_fail = 0;

    assign o_fail_count = n_fail;

    task automatic report_mismatch(input string what, input t_word got, input t_word want);
        if (n_fail < PRINT_CAP) begin
            $display("checker: %s got %08h want %08h at %0t", what, got, want, $time);
        end
        n_fail++;
    endtask

    task automatic reseed_accumulators();
        t_word s;
        case (cur_variant)
            VAR_6103: s = SEED_6103;
            VAR_6105: s = SEED_6105;
            VAR_6106: s = SEED_6106;
            default:  s = SEED_6102;
        endcase
        plain_sum   = s;
        carry_count = s;
        xor_sum     = s;
        rotate_sum  = s;
        compare_mix = s;
        mix_acc     = s;
    endtask

    // one image word through the accumulators, checksum queued when it closes a region
    task automatic absorb_word(input t_in_item it);
        t_word       d, r;
        logic [32:0] wide;
        logic [4:0]  amt;
        t_out_item   res;
        d    = it.image_word;
        amt  = d[4:0];
        wide = {1'b0, plain_sum} + {1'b0, d};
        if (wide[32]) begin
            carry_count = carry_count + 1;
        end
        plain_sum = wide[31:0];
        xor_sum   = xor_sum ^ d;
        r = (amt == 0) ? d : ((d << amt) | (d >> (32 - amt)));
        rotate_sum = rotate_sum + r;
        if (compare_mix > d) begin
            compare_mix = compare_mix ^ r;
        end else begin
            compare_mix = compare_mix ^ plain_sum ^ d;
        end
        if (cur_variant == VAR_6105) begin
            mix_acc = mix_acc + (it.boot_word ^ d);
        end else begin
            mix_acc = mix_acc + (rotate_sum ^ d);
        end
        if (it.last) begin
            case (cur_variant)
                VAR_6103: begin
                    res.checksum_first  = (plain_sum ^ carry_count) + xor_sum;
                    res.checksum_second = (rotate_sum ^ compare_mix) + mix_acc;
                end
                VAR_6106: begin
                    res.checksum_first  = plain_sum * carry_count + xor_sum;
                    res.checksum_second = rotate_sum * compare_mix + mix_acc;
                end
                default: begin
                    res.checksum_first  = plain_sum ^ carry_count ^ xor_sum;
                    res.checksum_second = rotate_sum ^ compare_mix ^ mix_acc;
                end
            endcase
            checksum_q.push_back(res);
            reseed_accumulators();
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            cur_variant = VAR_6102;
            reseed_accumulators();
            checksum_q.delete();
        end else begin
            if (i_cfg_we) begin
                cur_variant = i_cfg_wdata;
                reseed_accumulators();
            end
            if (i_push && !i_full) begin
                absorb_word(i_item);
            end
            if (i_pop && !i_empty) begin
                if (checksum_q.size() == 0) begin
                    report_mismatch("result with no checksum pending",
                                    i_result.checksum_first, '0);
                end else begin
                    want = checksum_q.pop_front();
                    if (i_result.checksum_first !== want.checksum_first) begin
                        report_mismatch("checksum_first", i_result.checksum_first,
                                        want.checksum_first);
                    end
                    if (i_result.checksum_second !== want.checksum_second) begin
                        report_mismatch("checksum_second", i_result.checksum_second,
                                        want.checksum_second);
                    end
                end
            end
        end
        o_pending <= checksum_q.size();
    end

endmodule

// ----- sim/tb_top.sv -----
// tb_top: stimulus, clock, reset and verdict for cartridge_boot_checksum_core
// depends on cbc_pkg, the core itself and cbc_checker, which predicts and compares
`timescale 1ns / 1ps

module tb_top;
    import cbc_pkg::*;

    // hold-off long enough to fill the snapshot and result queues several times over
    localparam int HOLD_CYCLES    = 300;
    // a result passes the snapshot queue, back end register and result queue;
    // leave a margin before config writes and the verdict
    localparam int SETTLE_CYCLES  = 8;
    // cycles with no transfer or config write before the run is declared hung
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_WORDS    = 85;
    localparam int NUM_PHASES     = 8;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cfg_we    = 1'b0;
    t_variant  cfg_wdata = VAR_6102;
    logic      push      = 1'b0;
    logic      full;
    t_in_item  item      = '0;
    logic      empty;
    logic      pop       = 1'b0;
    t_out_item result;

    int sum_fails;
    int checksums_pending;

    // sender bookkeeping: push_hi mirrors what was last scheduled onto push
    bit push_hi    = 1'b0;
    int burst_left = 0;
    // set by the stimulus, taken by the receiver to start its long hold-off
    bit hold_go    = 1'b0;
    int idle_cycles = 0;

    t_variant dir_vars[3]   = '{VAR_6103, VAR_6105, VAR_6106};
    t_variant phase_vars[4] = '{VAR_6103, VAR_6106, VAR_6102, VAR_6105};

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    cartridge_boot_checksum_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .push        (push),
        .full        (full),
        .i_item      (item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (result)
    );

    cbc_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_push       (push),
        .i_full       (full),
        .i_item       (item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (result),
        .o_fail_count (sum_fails),
        .o_pending    (checksums_pending)
    );

    // image and boot words lean on the corner values: zero, all ones,
    // a zero rotate amount and single set bits
    function automatic t_word pick_word();
        t_word w;
        case ($urandom_range(0, 7))
            0:       w = '0;
            1:       w = '1;
            2:       w = $urandom & ~32'h1F;
            3:       w = 32'h1 << $urandom_range(0, 31);
            default: w = $urandom;
        endcase
        return w;
    endfunction

    function automatic t_in_item make_word_item(input t_word d, input t_word b, input logic l);
        t_in_item it;
        it.image_word = d;
        it.boot_word  = b;
        it.last       = l;
        return it;
    endfunction

    // offer one word and wait for its transfer; bursts end in a random gap
    task automatic offer(input t_in_item it);
        push    <= 1'b1;
        item    <= it;
        push_hi  = 1'b1;
        do @(posedge clk); while (full);
        burst_left--;
        if (burst_left <= 0) begin
            push    <= 1'b0;
            push_hi  = 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            // now and then a long stretch with no gaps at all
            burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 20);
        end
    endtask

    // stop offering and let every pending checksum drain out
    task automatic quiesce();
        if (push_hi) begin
            push    <= 1'b0;
            push_hi  = 1'b0;
        end
        do @(posedge clk); while (checksums_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_variant(input t_variant v);
        quiesce();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // short region that hits both compare branches, a carry and a zero rotate
    task automatic directed_region();
        offer(make_word_item(32'h0000_0000, 32'hFFFF_FFFF, 1'b0));
        offer(make_word_item(32'hFFFF_FFFF, 32'h0000_0000, 1'b0));
        offer(make_word_item(32'h8000_0000, 32'h1234_5678, 1'b0));
        offer(make_word_item(32'h0000_0020, 32'hFFFF_FFFF, 1'b1));
    endtask

    task automatic stream_region(input int len, input bit closed);
        t_in_item it;
        for (int i = 0; i < len; i++) begin
            it.image_word = pick_word();
            it.boot_word  = pick_word();
            it.last       = closed && (i == len - 1);
            offer(it);
        end
    endtask

    // stimulus
    initial begin : stimulus
        int sent;
        int len;
        bit closed;
        repeat (2) @(posedge clk);
        rst_n      <= 1'b1;
        burst_left  = $urandom_range(1, 20);

        // reset variant first, then a one-word region with a rotate amount of 31
        directed_region();
        offer(make_word_item(32'h0000_001F, 32'h0000_0000, 1'b1));
        foreach (dir_vars[k]) begin
            write_variant(dir_vars[k]);
            directed_region();
        end
        // open region thrown away by a variant write
        offer(make_word_item(32'hDEAD_BEEF, 32'h0F0F_0F0F, 1'b0));
        offer(make_word_item(32'h0000_0007, 32'hF0F0_F0F0, 1'b0));
        write_variant(VAR_6105);
        offer(make_word_item(32'hFFFF_FFE0, 32'hFFFF_FFFF, 1'b1));

        // random regions, mostly short and closed, a few long or left open
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_variant(ph < 4 ? phase_vars[ph] : t_variant'($urandom_range(0, 3)));
            if (ph == 1) begin
                hold_go = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_WORDS) begin
                len    = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 80)
                                                       : $urandom_range(1, 12);
                closed = ($urandom_range(0, 15) != 0);
                stream_region(len, closed);
                sent += len;
            end
        end

        quiesce();
        if (sum_fails == 0 && checksums_pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // receiver: pops on a pattern of its own, with one long hold-off on request
    initial begin : receiver
        int mode;
        int stretch;
        wait (rst_n);
        forever begin
            mode    = $urandom_range(0, 2);
            stretch = $urandom_range(5, 60);
            if (hold_go) begin
                hold_go = 1'b0;
                repeat (HOLD_CYCLES) begin
                    pop <= 1'b0;
                    @(posedge clk);
                end
            end
            repeat (stretch) begin
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= ($urandom_range(0, 1) == 1);
                    default: pop <= ($urandom_range(0, 7) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // watchdog: any transfer or config write counts as progress
    always @(posedge clk) begin
        if (!rst_n || (push && !full) || (pop && !empty) || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
